// File: rtl/core/rttp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rttp_pkg
// Shared types, constants and the micro-program table of the ringtone text
// note parser.
// ----------------------------------------------------------------------------
package rttp_pkg;

    // build-time octave offset default
    localparam int unsigned OCTAVE_SHIFT_DEF = 0;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned ACC_W    = 10;
    localparam int unsigned DLEN_W   = 8;
    localparam int unsigned OCT_W    = 4;
    localparam int unsigned SEMI_W   = 4;
    localparam int unsigned WHOLE_W  = 18;
    localparam int unsigned DUR_W    = 19;
    localparam int unsigned UPC_W    = 4;
    localparam int unsigned DCNT_W   = 5;

    localparam logic [ACC_W-1:0]   ACC_MAX       = 10'd1023;
    localparam logic [DLEN_W-1:0]  DLEN_RESET    = 8'd4;
    localparam logic [OCT_W-1:0]   OCT_RESET     = 4'd6;
    localparam logic [ACC_W-1:0]   TEMPO_RESET   = 10'd63;
    localparam logic [WHOLE_W-1:0] MS_PER_MINUTE = 18'd60000;
    localparam logic [DCNT_W-1:0]  DIV_STEPS     = 5'd18;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2c;
    localparam logic [CHAR_W-1:0] CH_SHARP = 8'h23;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_3     = 8'h33;
    localparam logic [CHAR_W-1:0] CH_7     = 8'h37;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_B     = 8'h62;
    localparam logic [CHAR_W-1:0] CH_C     = 8'h63;
    localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
    localparam logic [CHAR_W-1:0] CH_E     = 8'h65;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h66;
    localparam logic [CHAR_W-1:0] CH_G     = 8'h67;
    localparam logic [CHAR_W-1:0] CH_O     = 8'h6f;

    typedef enum logic [3:0] {
        PH_NAME   = 4'd0,
        PH_HD     = 4'd1,
        PH_DSKIP  = 4'd2,
        PH_DDIG   = 4'd3,
        PH_HO     = 4'd4,
        PH_OSKIP  = 4'd5,
        PH_ODIG   = 4'd6,
        PH_OCOMMA = 4'd7,
        PH_HB     = 4'd8,
        PH_BSKIP  = 4'd9,
        PH_BDIG   = 4'd10,
        PH_NDUR   = 4'd11,
        PH_NSHARP = 4'd12,
        PH_NDOT   = 4'd13,
        PH_NOCT   = 4'd14,
        PH_NEND   = 4'd15
    } t_phase;

    typedef enum logic [2:0] {
        UOP_NONE,
        UOP_LOAD,
        UOP_EXEC,
        UOP_DIV_START,
        UOP_DIV_STEP,
        UOP_DIV_STORE,
        UOP_EMIT
    } t_uop;

    typedef enum logic [2:0] {
        UC_NEVER,
        UC_ALWAYS,
        UC_NO_BEAT,
        UC_NEED_DIV,
        UC_NEED_EMIT,
        UC_AGAIN,
        UC_DIV_BUSY,
        UC_OUT_BUSY
    } t_ucond;

    typedef struct packed {
        t_uop              op;
        t_ucond            cond;
        logic [UPC_W-1:0]  target;
    } t_uword;

    localparam logic [UPC_W-1:0] UA_WAIT      = 4'd0;
    localparam logic [UPC_W-1:0] UA_EXEC      = 4'd1;
    localparam logic [UPC_W-1:0] UA_BR_DIV    = 4'd2;
    localparam logic [UPC_W-1:0] UA_BR_EMIT   = 4'd3;
    localparam logic [UPC_W-1:0] UA_BR_AGAIN  = 4'd4;
    localparam logic [UPC_W-1:0] UA_RET       = 4'd5;
    localparam logic [UPC_W-1:0] UA_DIV_INIT  = 4'd6;
    localparam logic [UPC_W-1:0] UA_DIV_STEP  = 4'd7;
    localparam logic [UPC_W-1:0] UA_DIV_END   = 4'd8;
    localparam logic [UPC_W-1:0] UA_EMIT      = 4'd9;
    localparam logic [UPC_W-1:0] UA_EMIT_RET  = 4'd10;

    // micro-program: jump to target when cond holds, else fall through
    function automatic t_uword useq_rom(input logic [UPC_W-1:0] addr);
        t_uword w;
        w = '{op: UOP_NONE, cond: UC_ALWAYS, target: UA_WAIT};
        case (addr)
            UA_WAIT:     w = '{op: UOP_LOAD,      cond: UC_NO_BEAT,   target: UA_WAIT};
            UA_EXEC:     w = '{op: UOP_EXEC,      cond: UC_NEVER,     target: UA_WAIT};
            UA_BR_DIV:   w = '{op: UOP_NONE,      cond: UC_NEED_DIV,  target: UA_DIV_INIT};
            UA_BR_EMIT:  w = '{op: UOP_NONE,      cond: UC_NEED_EMIT, target: UA_EMIT};
            UA_BR_AGAIN: w = '{op: UOP_NONE,      cond: UC_AGAIN,     target: UA_EXEC};
            UA_RET:      w = '{op: UOP_NONE,      cond: UC_ALWAYS,    target: UA_WAIT};
            UA_DIV_INIT: w = '{op: UOP_DIV_START, cond: UC_NEVER,     target: UA_WAIT};
            UA_DIV_STEP: w = '{op: UOP_DIV_STEP,  cond: UC_DIV_BUSY,  target: UA_DIV_STEP};
            UA_DIV_END:  w = '{op: UOP_DIV_STORE, cond: UC_ALWAYS,    target: UA_BR_AGAIN};
            UA_EMIT:     w = '{op: UOP_EMIT,      cond: UC_OUT_BUSY,  target: UA_EMIT};
            UA_EMIT_RET: w = '{op: UOP_NONE,      cond: UC_ALWAYS,    target: UA_BR_AGAIN};
            default:     w = '{op: UOP_NONE,      cond: UC_ALWAYS,    target: UA_WAIT};
        endcase
        return w;
    endfunction

    function automatic logic [SEMI_W-1:0] letter_code(input logic [CHAR_W-1:0] c);
        logic [SEMI_W-1:0] s;
        case (c)
            CH_C:    s = 4'd1;
            CH_D:    s = 4'd3;
            CH_E:    s = 4'd5;
            CH_F:    s = 4'd6;
            CH_G:    s = 4'd8;
            CH_A:    s = 4'd10;
            CH_B:    s = 4'd12;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/core/ringtone_text_note_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ringtone_text_note_parser_unit
// Parses ringtone text bytes into note records under a micro-program.
// ----------------------------------------------------------------------------
// Usage:
//   slave side takes one text byte per beat (tdata[7:0]); a zero byte ends a
//   tune. master side sends one note record per finished note: tuser is the
//   rest flag, tdata holds semitone, octave and duration in ms.
//   A byte is taken only while the sequencer sits in its wait step, so
//   bytes are handled one at a time. A plain byte runs the exec and branch
//   steps before the next ready. A byte that closes a note letter or the
//   header also runs the 18-step restoring divider; a byte that both
//   closes the header and starts a note runs it twice.
//   A record leaves through an output register, so the next byte is taken
//   while a record still waits. If the receiver stalls and a second record
//   is due, the sequencer holds in its emit step until the first is taken.
//   Reset returns to skipping the tune name with defaults duration 4,
//   octave 6 and tempo 63 bpm, and drops any waiting record.
// ----------------------------------------------------------------------------
module ringtone_text_note_parser_unit
    import rttp_pkg::*;
#(
    parameter int unsigned OCTAVE_SHIFT = OCTAVE_SHIFT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_code
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [3:0] semitone, [7:4] octave, [26:8] duration_ms
    output logic        o_m_tuser    // [0] is_rest
);

    // sequencer
    logic [UPC_W-1:0] r_upc, n_upc;
    t_uword           uw;
    logic             cond_hit;

    // parser state
    t_phase             r_phase, n_phase;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [DLEN_W-1:0]  r_dlen, n_dlen;
    logic [OCT_W-1:0]   r_doct, n_doct;
    logic [ACC_W-1:0]   r_tempo, n_tempo;
    logic [WHOLE_W-1:0] r_whole, n_whole;
    logic [SEMI_W-1:0]  r_pend_semi, n_pend_semi;
    logic [DUR_W-1:0]   r_pend_dur, n_pend_dur;
    logic [OCT_W-1:0]   r_pend_oct, n_pend_oct;
    logic [CHAR_W-1:0]  r_char, n_char;

    // step outcome flags
    logic r_need_div, n_need_div;
    logic r_need_emit, n_need_emit;
    logic r_again, n_again;

    // divider
    logic [WHOLE_W-1:0] r_dvd, n_dvd;
    logic [ACC_W-1:0]   r_dvs, n_dvs;
    logic [ACC_W-1:0]   r_rem, n_rem;
    logic [DCNT_W-1:0]  r_dcnt, n_dcnt;
    logic               r_div_note, n_div_note;
    logic [ACC_W:0]     rem_sh;
    logic [ACC_W:0]     rem_diff;
    logic               rem_ge;

    // output register
    logic               r_out_valid, n_out_valid;
    logic               r_out_rest, n_out_rest;
    logic [SEMI_W-1:0]  r_out_semi, n_out_semi;
    logic [OCT_W-1:0]   r_out_oct, n_out_oct;
    logic [DUR_W-1:0]   r_out_dur, n_out_dur;

    // byte decode
    logic               is_digit;
    logic [13:0]        acc_prod;
    logic [13:0]        acc_sum;
    logic [ACC_W-1:0]   acc_next;
    logic [ACC_W-1:0]   note_div;
    logic [ACC_W-1:0]   bpm_src;
    logic               out_busy;

    assign uw       = useq_rom(r_upc);
    assign out_busy = r_out_valid && !i_m_tready;
    assign is_digit = (r_char >= CH_0) && (r_char <= CH_9);
    assign acc_prod = {4'b0, r_acc} * 14'd10;
    assign acc_sum  = acc_prod + {10'b0, r_char[3:0]};
    assign acc_next = (acc_sum > {4'b0, ACC_MAX}) ? ACC_MAX : acc_sum[ACC_W-1:0];
    assign note_div = (r_acc != '0) ? r_acc : {2'b0, r_dlen};
    // tempo written by the b= field closes into the divider in the same step
    assign bpm_src  = (r_phase == PH_BDIG) ? r_acc : r_tempo;

    assign rem_sh   = {r_rem, r_dvd[WHOLE_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_dvs};
    assign rem_diff = rem_sh - {1'b0, r_dvs};

    always_comb begin
        case (uw.cond)
            UC_NEVER:     cond_hit = 1'b0;
            UC_ALWAYS:    cond_hit = 1'b1;
            UC_NO_BEAT:   cond_hit = !i_s_tvalid;
            UC_NEED_DIV:  cond_hit = r_need_div;
            UC_NEED_EMIT: cond_hit = r_need_emit;
            UC_AGAIN:     cond_hit = r_again;
            UC_DIV_BUSY:  cond_hit = r_dcnt != 5'd1;
            UC_OUT_BUSY:  cond_hit = out_busy;
            default:      cond_hit = 1'b0;
        endcase
        n_upc = cond_hit ? uw.target : r_upc + 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_WAIT;
        end else begin
            r_upc <= n_upc;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_dlen      = r_dlen;
        n_doct      = r_doct;
        n_tempo     = r_tempo;
        n_whole     = r_whole;
        n_pend_semi = r_pend_semi;
        n_pend_dur  = r_pend_dur;
        n_pend_oct  = r_pend_oct;
        n_char      = r_char;
        n_need_div  = r_need_div;
        n_need_emit = r_need_emit;
        n_again     = r_again;
        n_dvd       = r_dvd;
        n_dvs       = r_dvs;
        n_rem       = r_rem;
        n_dcnt      = r_dcnt;
        n_div_note  = r_div_note;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_rest  = r_out_rest;
        n_out_semi  = r_out_semi;
        n_out_oct   = r_out_oct;
        n_out_dur   = r_out_dur;

        case (uw.op)
            UOP_LOAD: begin
                n_char = i_s_tdata;
            end
            UOP_EXEC: begin
                n_need_div  = 1'b0;
                n_need_emit = 1'b0;
                n_again     = 1'b0;
                if (r_char == CH_NUL && r_phase >= PH_HD && r_phase <= PH_NDUR) begin
                    n_phase = PH_NAME;
                    n_acc   = '0;
                end else begin
                    case (r_phase)
                        PH_NAME: begin
                            if (r_char == CH_COLON) begin
                                n_dlen  = DLEN_RESET;
                                n_doct  = OCT_RESET;
                                n_tempo = TEMPO_RESET;
                                n_phase = PH_HD;
                            end
                        end
                        PH_HD: begin
                            if (r_char == CH_D) begin
                                n_phase = PH_DSKIP;
                            end else begin
                                n_phase = PH_HO;
                                n_again = 1'b1;
                            end
                        end
                        PH_DSKIP: begin
                            n_acc   = '0;
                            n_phase = PH_DDIG;
                        end
                        PH_DDIG: begin
                            if (is_digit) begin
                                n_acc = acc_next;
                            end else begin
                                if (r_acc != '0) n_dlen = r_acc[DLEN_W-1:0];
                                n_acc   = '0;
                                n_phase = PH_HO;
                            end
                        end
                        PH_HO: begin
                            if (r_char == CH_O) begin
                                n_phase = PH_OSKIP;
                            end else begin
                                n_phase = PH_HB;
                                n_again = 1'b1;
                            end
                        end
                        PH_OSKIP: begin
                            n_phase = PH_ODIG;
                        end
                        PH_ODIG: begin
                            if (r_char >= CH_3 && r_char <= CH_7) n_doct = r_char[3:0];
                            n_phase = PH_OCOMMA;
                        end
                        PH_OCOMMA: begin
                            n_phase = PH_HB;
                        end
                        PH_HB, PH_BDIG: begin
                            if (r_phase == PH_HB && r_char == CH_B) begin
                                n_phase = PH_BSKIP;
                            end else if (r_phase == PH_BDIG && is_digit) begin
                                n_acc = acc_next;
                            end else begin
                                // header done: whole note = 60000 / bpm, times 4 later
                                if (r_phase == PH_BDIG) n_tempo = r_acc;
                                n_again    = (r_phase == PH_HB);
                                n_need_div = 1'b1;
                                n_div_note = 1'b0;
                                n_dvd      = MS_PER_MINUTE;
                                n_dvs      = (bpm_src == '0) ? 10'd1 : bpm_src;
                                n_acc      = '0;
                                n_phase    = PH_NDUR;
                            end
                        end
                        PH_BSKIP: begin
                            n_acc   = '0;
                            n_phase = PH_BDIG;
                        end
                        PH_NDUR: begin
                            if (is_digit) begin
                                n_acc = acc_next;
                            end else begin
                                n_need_div  = 1'b1;
                                n_div_note  = 1'b1;
                                n_dvd       = r_whole;
                                n_dvs       = (note_div == '0) ? 10'd1 : note_div;
                                n_pend_semi = letter_code(r_char);
                                n_acc       = '0;
                                n_phase     = PH_NSHARP;
                            end
                        end
                        PH_NSHARP: begin
                            if (r_char == CH_SHARP) n_pend_semi = r_pend_semi + 4'd1;
                            else n_again = 1'b1;
                            n_phase = PH_NDOT;
                        end
                        PH_NDOT: begin
                            if (r_char == CH_DOT) n_pend_dur = r_pend_dur + (r_pend_dur >> 1);
                            else n_again = 1'b1;
                            n_phase = PH_NOCT;
                        end
                        PH_NOCT: begin
                            if (is_digit) begin
                                n_pend_oct = r_char[3:0];
                            end else begin
                                n_pend_oct = r_doct;
                                n_again    = 1'b1;
                            end
                            n_phase = PH_NEND;
                        end
                        PH_NEND: begin
                            n_need_emit = 1'b1;
                            n_acc       = '0;
                            if (r_char == CH_NUL) begin
                                n_phase = PH_NAME;
                            end else begin
                                n_phase = PH_NDUR;
                                n_again = r_char != CH_COMMA;
                            end
                        end
                        default: begin
                            n_phase = PH_NAME;
                        end
                    endcase
                end
            end
            UOP_DIV_START: begin
                n_rem  = '0;
                n_dcnt = DIV_STEPS;
            end
            UOP_DIV_STEP: begin
                // restoring division, one quotient bit per cycle into the low end
                n_rem  = rem_ge ? rem_diff[ACC_W-1:0] : rem_sh[ACC_W-1:0];
                n_dvd  = {r_dvd[WHOLE_W-2:0], rem_ge};
                n_dcnt = r_dcnt - 5'd1;
            end
            UOP_DIV_STORE: begin
                if (r_div_note) n_pend_dur = {1'b0, r_dvd};
                else n_whole = {r_dvd[15:0], 2'b00};
            end
            UOP_EMIT: begin
                if (!out_busy) begin
                    n_out_valid = 1'b1;
                    n_out_rest  = r_pend_semi == '0;
                    n_out_semi  = r_pend_semi;
                    n_out_oct   = r_pend_oct + OCT_W'(OCTAVE_SHIFT);
                    n_out_dur   = r_pend_dur;
                end
            end
            default: begin
                n_char = r_char;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_NAME;
            r_acc       <= '0;
            r_dlen      <= DLEN_RESET;
            r_doct      <= OCT_RESET;
            r_tempo     <= TEMPO_RESET;
            r_whole     <= '0;
            r_pend_semi <= '0;
            r_pend_dur  <= '0;
            r_pend_oct  <= '0;
            r_need_div  <= 1'b0;
            r_need_emit <= 1'b0;
            r_again     <= 1'b0;
            r_dcnt      <= '0;
            r_div_note  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_dlen      <= n_dlen;
            r_doct      <= n_doct;
            r_tempo     <= n_tempo;
            r_whole     <= n_whole;
            r_pend_semi <= n_pend_semi;
            r_pend_dur  <= n_pend_dur;
            r_pend_oct  <= n_pend_oct;
            r_need_div  <= n_need_div;
            r_need_emit <= n_need_emit;
            r_again     <= n_again;
            r_dcnt      <= n_dcnt;
            r_div_note  <= n_div_note;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_dvd      <= n_dvd;
        r_dvs      <= n_dvs;
        r_rem      <= n_rem;
        r_out_rest <= n_out_rest;
        r_out_semi <= n_out_semi;
        r_out_oct  <= n_out_oct;
        r_out_dur  <= n_out_dur;
    end

    assign o_s_tready = uw.op == UOP_LOAD;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_rest;
    assign o_m_tdata  = {5'b0, r_out_dur, r_out_oct, r_out_semi};

endmodule

// File: rtl/core/rttp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rttp_checker
// Port-level checks of the ringtone text note parser, bound to the top level.
// ----------------------------------------------------------------------------
module rttp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tuser
);

    // a stalled record holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled record changed");

    // bytes are handled one at a time
    a_one_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && $stable(i_s_tdata) |=> !o_s_tready)
        else $error("ready right after a byte beat");

    // rest flag agrees with semitone
    a_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == (o_m_tdata[3:0] == 4'd0)))
        else $error("rest flag mismatch");

    // padding stays zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[31:27] == 5'd0))
        else $error("padding bits set");

    // reset drops any waiting record
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("record valid after reset");

endmodule

bind ringtone_text_note_parser_unit rttp_checker u_rttp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
